// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/cfir_pkg.sv -----
// shared types and constants of the complex fir filter
`default_nettype none

package cfir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TAP_W       = 32;
    localparam int PROD_W      = 32;
    localparam int TERM_W      = 33;
    localparam int ACC_W       = 35;
    localparam int COEFF_PAIRS = 4;
    localparam int COEFF_TAPS  = 8;
    localparam int TAP_IDX_W   = 3;
    localparam int TAP_COUNT_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT    = 3'd0,
        REG_COEFF_PAIR_0 = 3'd1,
        REG_COEFF_PAIR_1 = 3'd2,
        REG_COEFF_PAIR_2 = 3'd3,
        REG_COEFF_PAIR_3 = 3'd4
    } cfg_reg_e;

    // one complex value, real in the low half
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] im;
        logic signed [SAMPLE_W-1:0] re;
    } cplx_t;

    typedef cplx_t [COEFF_TAPS-1:0] coeff_bank_t;

    // control that travels with one tap through the mac
    typedef struct packed {
        logic first;
        logic last;
        logic keep;
    } mac_tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfir_if.sv -----
// channel interfaces: samples in, results out, configuration writes
`default_nettype none

interface cfir_sample_if import cfir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic                       last_sample;

    modport source (output valid, sample_re, sample_im, last_sample, input ready);
    modport sink   (input valid, sample_re, sample_im, last_sample, output ready);
endinterface

interface cfir_result_if import cfir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] out_re;
    logic signed [ACC_W-1:0] out_im;
    logic                    last_out;

    modport source (output valid, out_re, out_im, last_out, input ready);
    modport sink   (input valid, out_re, out_im, last_out, output ready);
endinterface

interface cfir_cfg_if import cfir_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfir_win_mem.sv -----
// sample window memory, one write and one registered read port
`default_nettype none

module cfir_win_mem
    import cfir_pkg::*;
#(
    parameter int ADDR_W = 3
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire cplx_t             wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output cplx_t                  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    cplx_t mem [DEPTH];
    cplx_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cfir_cmac.sv -----
// shared complex multiply-accumulate, products then accumulator
`default_nettype none

module cfir_cmac
    import cfir_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              vld,
    input  wire mac_tag_t          tag,
    input  wire cplx_t             coeff,
    input  wire cplx_t             sample,
    output logic                   done,
    output logic signed [ACC_W-1:0] acc_re,
    output logic signed [ACC_W-1:0] acc_im
);

    `include "assert_macros.svh"

    logic                     prod_vld_reg;
    mac_tag_t                 prod_tag_reg;
    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_ri_reg;
    logic signed [PROD_W-1:0] p_ir_reg;

    logic                    done_reg;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;

    cplx_t                   x;
    logic signed [TERM_W-1:0] term_re;
    logic signed [TERM_W-1:0] term_im;
    logic signed [ACC_W-1:0]  base_re;
    logic signed [ACC_W-1:0]  base_im;

    // window entries outside the live samples read as zero
    assign x = tag.keep ? sample : '0;

    // control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= vld;
            done_reg     <= prod_vld_reg && prod_tag_reg.last;
        end
    end

    // four partial products
    always_ff @(posedge clk)
    begin
        if (vld)
        begin
            prod_tag_reg <= tag;
            p_rr_reg     <= coeff.re * x.re;
            p_ii_reg     <= coeff.im * x.im;
            p_ri_reg     <= coeff.re * x.im;
            p_ir_reg     <= coeff.im * x.re;
        end
    end

    // combine and accumulate, wrapping at the output width
    always_comb
    begin
        term_re = {p_rr_reg[PROD_W-1], p_rr_reg} - {p_ii_reg[PROD_W-1], p_ii_reg};
        term_im = {p_ri_reg[PROD_W-1], p_ri_reg} + {p_ir_reg[PROD_W-1], p_ir_reg};
        base_re = prod_tag_reg.first ? '0 : acc_re_reg;
        base_im = prod_tag_reg.first ? '0 : acc_im_reg;
    end

    always_ff @(posedge clk)
    begin
        if (prod_vld_reg)
        begin
            acc_re_reg <= base_re + {{(ACC_W-TERM_W){term_re[TERM_W-1]}}, term_re};
            acc_im_reg <= base_im + {{(ACC_W-TERM_W){term_im[TERM_W-1]}}, term_im};
        end
    end

    assign done   = done_reg;
    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

    // the final tap of a sum is always followed by a finished sum
    `ASSERT_CLK(a_last_tap_done, prod_vld_reg && prod_tag_reg.last |=> done_reg,
        "last tap did not finish a sum")

endmodule

`default_nettype wire

// ----- rtl/core/cfir_ctrl.sv -----
// sequencer: window writes, tap reads, flush and output register
`default_nettype none

module cfir_ctrl
    import cfir_pkg::*;
#(
    parameter int TAPS = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    cfir_sample_if.sink        samples,
    cfir_result_if.source      results,
    input  wire logic [((TAPS + 1) > 2 ? $clog2(TAPS + 1) : 1)-1:0] m_taps,
    input  wire coeff_bank_t   coeffs,
    output logic               mem_we,
    output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] mem_waddr,
    output cplx_t              mem_wdata,
    output logic               mem_re,
    output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] mem_raddr,
    output logic               mac_vld,
    output mac_tag_t           mac_tag,
    output cplx_t              mac_coeff,
    input  wire logic          mac_done,
    input  wire logic signed [ACC_W-1:0] mac_acc_re,
    input  wire logic signed [ACC_W-1:0] mac_acc_im
);

    `include "assert_macros.svh"

    localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = ((TAPS + 1) > 2) ? $clog2(TAPS + 1) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t             state_reg,    state_next;
    logic [PTR_W-1:0]   wp_reg,       wp_next;
    logic [CNT_W-1:0]   fill_reg,     fill_next;
    logic [PTR_W-1:0]   skip_reg,     skip_next;
    logic [CNT_W-1:0]   left_reg,     left_next;
    logic               flush_reg,    flush_next;
    logic [PTR_W-1:0]   j_reg,        j_next;
    logic               iss_vld_reg,  iss_vld_next;
    mac_tag_t           iss_tag_reg,  iss_tag_next;
    cplx_t              iss_coeff_reg, iss_coeff_next;
    logic               out_vld_reg,  out_vld_next;
    logic signed [ACC_W-1:0] out_re_reg, out_re_next;
    logic signed [ACC_W-1:0] out_im_reg, out_im_next;
    logic               out_last_reg, out_last_next;

    logic             accept;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] cnt;
    logic [PTR_W-1:0] diff;
    logic             emit_now;
    logic             slot_free;

    assign accept    = samples.valid && samples.ready;
    assign slot_free = !out_vld_reg || results.ready;
    assign emit_now  = (state_reg == ST_HOLD) || ((state_reg == ST_DRAIN) && mac_done);

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        skip_next      = skip_reg;
        left_next      = left_reg;
        flush_next     = flush_reg;
        j_next         = j_reg;
        iss_vld_next   = 1'b0;
        iss_tag_next   = iss_tag_reg;
        iss_coeff_next = iss_coeff_reg;
        out_vld_next   = out_vld_reg && !results.ready;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        out_last_next  = out_last_reg;
        mem_re         = 1'b0;
        mem_raddr      = wp_reg - PTR_W'(1) - j_reg + skip_reg;
        diff           = j_reg - skip_reg;

        fill_inc = (fill_reg == CNT_W'(TAPS)) ? fill_reg : fill_reg + CNT_W'(1);
        cnt      = (fill_inc < m_taps) ? fill_inc : m_taps;

        case (state_reg)
            ST_IDLE:
            begin
                // take one item into the window
                if (accept)
                begin
                    wp_next   = wp_reg + PTR_W'(1);
                    fill_next = fill_inc;
                    j_next    = '0;
                    if (samples.last_sample)
                    begin
                        // pad up to m taps, then one output per live sample
                        state_next = ST_RUN;
                        skip_next  = PTR_W'(m_taps - cnt);
                        left_next  = cnt;
                        flush_next = 1'b1;
                    end
                    else if (fill_inc >= m_taps)
                    begin
                        state_next = ST_RUN;
                        skip_next  = '0;
                        left_next  = CNT_W'(1);
                        flush_next = 1'b0;
                    end
                end
            end
            ST_RUN:
            begin
                // one window read and one coefficient per cycle
                mem_re                = 1'b1;
                iss_vld_next          = 1'b1;
                iss_tag_next.first    = (j_reg == '0);
                iss_tag_next.last     = (CNT_W'(j_reg) == m_taps - CNT_W'(1));
                iss_tag_next.keep     = (j_reg >= skip_reg) && (CNT_W'(diff) < fill_reg);
                iss_coeff_next        = coeffs[TAP_IDX_W'(j_reg)];
                j_next                = j_reg + PTR_W'(1);
                if (iss_tag_next.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN, ST_HOLD:
            begin
                if (emit_now)
                begin
                    if (slot_free)
                    begin
                        // hand the sum to the output register
                        out_vld_next  = 1'b1;
                        out_re_next   = mac_acc_re;
                        out_im_next   = mac_acc_im;
                        out_last_next = flush_reg && (left_reg == CNT_W'(1));
                        left_next     = left_reg - CNT_W'(1);
                        skip_next     = skip_reg + PTR_W'(1);
                        j_next        = '0;
                        if (left_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                            if (flush_reg)
                            begin
                                fill_next = '0;
                            end
                        end
                        else
                        begin
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            skip_reg     <= '0;
            left_reg     <= '0;
            flush_reg    <= 1'b0;
            j_reg        <= '0;
            iss_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            skip_reg     <= skip_next;
            left_reg     <= left_next;
            flush_reg    <= flush_next;
            j_reg        <= j_next;
            iss_vld_reg  <= iss_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        iss_tag_reg   <= iss_tag_next;
        iss_coeff_reg <= iss_coeff_next;
        out_re_reg    <= out_re_next;
        out_im_reg    <= out_im_next;
        out_last_reg  <= out_last_next;
    end

    // window write port
    assign mem_we    = accept;
    assign mem_waddr = wp_reg;
    assign mem_wdata = {samples.sample_im, samples.sample_re};

    // mac feed, aligned with the registered window read
    assign mac_vld   = iss_vld_reg;
    assign mac_tag   = iss_tag_reg;
    assign mac_coeff = iss_coeff_reg;

    // channel handshakes
    assign samples.ready    = (state_reg == ST_IDLE);
    assign results.valid    = out_vld_reg;
    assign results.out_re   = out_re_reg;
    assign results.out_im   = out_im_reg;
    assign results.last_out = out_last_reg;

    `ASSERT_CLK(a_done_in_drain, mac_done |-> state_reg == ST_DRAIN,
        "finished sum arrived outside drain")
    `ASSERT_CLK(a_busy_has_work, state_reg != ST_IDLE |-> left_reg != '0,
        "busy with no output pending")
    `ASSERT_CLK(a_skip_in_range, state_reg == ST_RUN |-> CNT_W'(skip_reg) < m_taps,
        "zero padding reaches the tap count")

endmodule

`default_nettype wire

// ----- rtl/core/complex_fir_filter.sv -----
// complex fir filter top level: configuration registers and block wiring
//
//  channel   role   handshake        payload
//  samples   sink   valid / ready    sample_re, sample_im, last_sample
//  results   source valid / ready    out_re, out_im, last_out
//  cfg       sink   valid / ready    reg_index, wdata
//
// an item that releases an output starts m window reads through the single
// memory read port into one shared complex mac; the sum then passes the read,
// product and accumulate registers, and no item is taken meanwhile. an item
// that releases nothing is only stored; a last item releases its n outputs.
// reset is asynchronous, active low; the window needs no clearing pass since
// entries past the fill count read as zero. a stalled result waits in the
// output register while the next item's sum is formed.
`default_nettype none

module complex_fir_filter
    import cfir_pkg::*;
#(
    parameter int TAPS = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    cfir_sample_if.sink   samples,
    cfir_result_if.source results,
    cfir_cfg_if.sink      cfg
);

    localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W = ((TAPS + 1) > 2) ? $clog2(TAPS + 1) : 1;

    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic [CFG_DATA_W-1:0]  coeff_pair_reg [COEFF_PAIRS];

    logic [TAP_COUNT_W-1:0] m_clamp;
    logic [CNT_W-1:0]       m_taps;
    coeff_bank_t            coeffs;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    cplx_t            mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    cplx_t            mem_rdata;

    logic                    mac_vld;
    mac_tag_t                mac_tag;
    cplx_t                   mac_coeff;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_acc_re;
    logic signed [ACC_W-1:0] mac_acc_im;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_W'(1);
            for (int p = 0; p < COEFF_PAIRS; p++)
            begin
                coeff_pair_reg[p] <= '0;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_e'(cfg.reg_index))
                REG_TAP_COUNT:    tap_count_reg     <= cfg.wdata[TAP_COUNT_W-1:0];
                REG_COEFF_PAIR_0: coeff_pair_reg[0] <= cfg.wdata;
                REG_COEFF_PAIR_1: coeff_pair_reg[1] <= cfg.wdata;
                REG_COEFF_PAIR_2: coeff_pair_reg[2] <= cfg.wdata;
                REG_COEFF_PAIR_3: coeff_pair_reg[3] <= cfg.wdata;
                default:          ;
            endcase
        end
    end

    // active tap count, zero acts as one and large values clamp
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            m_clamp = TAP_COUNT_W'(1);
        end
        else if (tap_count_reg > TAP_COUNT_W'(TAPS))
        begin
            m_clamp = TAP_COUNT_W'(TAPS);
        end
        else
        begin
            m_clamp = tap_count_reg;
        end
    end

    assign m_taps = CNT_W'(m_clamp);

    // unpack coefficient pairs into taps
    always_comb
    begin
        for (int p = 0; p < COEFF_PAIRS; p++)
        begin
            coeffs[2*p]     = coeff_pair_reg[p][TAP_W-1:0];
            coeffs[2*p + 1] = coeff_pair_reg[p][2*TAP_W-1:TAP_W];
        end
    end

    cfir_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .results    (results),
        .m_taps     (m_taps),
        .coeffs     (coeffs),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mac_vld    (mac_vld),
        .mac_tag    (mac_tag),
        .mac_coeff  (mac_coeff),
        .mac_done   (mac_done),
        .mac_acc_re (mac_acc_re),
        .mac_acc_im (mac_acc_im)
    );

    cfir_win_mem #(
        .ADDR_W (PTR_W)
    ) u_win_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cfir_cmac u_cmac (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld    (mac_vld),
        .tag    (mac_tag),
        .coeff  (mac_coeff),
        .sample (mem_rdata),
        .done   (mac_done),
        .acc_re (mac_acc_re),
        .acc_im (mac_acc_im)
    );

endmodule

`default_nettype wire

// ----- tb/sv/cfir_tb_pkg.sv -----
// output predictor and result scoreboard for the complex fir filter testbench
package cfir_tb_pkg;
    import cfir_pkg::*;

    // one filter output as it leaves the result channel
    typedef struct packed {
        logic [ACC_W-1:0] re;
        logic [ACC_W-1:0] im;
        logic             last;
    } filt_out_t;

    class filter_scoreboard;
        logic [TAP_COUNT_W-1:0] tap_count;
        logic [CFG_DATA_W-1:0]  coeff_pair [COEFF_PAIRS];
        cplx_t                  window [COEFF_TAPS];
        int unsigned            fill;
        filt_out_t              pending_outputs [$];
        int unsigned            errors;

        function new();
            tap_count = 1;
            foreach (coeff_pair[p])
                coeff_pair[p] = '0;
            clear_window();
            errors = 0;
        endfunction

        function void clear_window();
            foreach (window[k])
                window[k] = '0;
            fill = 0;
        endfunction

        // mirror of a register write seen on the cfg channel
        function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TAP_COUNT:    tap_count = data[TAP_COUNT_W-1:0];
                REG_COEFF_PAIR_0: coeff_pair[0] = data;
                REG_COEFF_PAIR_1: coeff_pair[1] = data;
                REG_COEFF_PAIR_2: coeff_pair[2] = data;
                REG_COEFF_PAIR_3: coeff_pair[3] = data;
                default: ;
            endcase
        endfunction

        // zero acts as one tap, anything above the bank size as the full bank
        function int unsigned active_taps();
            int unsigned m;
            m = tap_count;
            if (m < 1)
                m = 1;
            if (m > COEFF_TAPS)
                m = COEFF_TAPS;
            return m;
        endfunction

        // newest sample sits in entry 0
        function void shift_window(cplx_t v);
            for (int k = COEFF_TAPS - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = v;
        endfunction

        // full precision complex dot product of coefficients and window
        function void push_tap_sum(int unsigned m, bit last);
            longint    acc_re;
            longint    acc_im;
            longint    cr, ci, xr, xi;
            cplx_t     c;
            filt_out_t r;
            acc_re = 0;
            acc_im = 0;
            for (int unsigned j = 0; j < m; j++) begin
                c  = coeff_pair[j / 2][(j % 2) * TAP_W +: TAP_W];
                cr = $signed(c.re);
                ci = $signed(c.im);
                xr = $signed(window[j].re);
                xi = $signed(window[j].im);
                acc_re += cr * xr - ci * xi;
                acc_im += cr * xi + ci * xr;
            end
            r.re   = acc_re[ACC_W-1:0];
            r.im   = acc_im[ACC_W-1:0];
            r.last = last;
            pending_outputs.push_back(r);
        endfunction

        // accepted sample: shift it in and queue the outputs it releases
        function void accept_sample(logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im,
                                    logic last);
            int unsigned m;
            int unsigned cnt;
            cplx_t       v;
            m    = active_taps();
            v.re = re;
            v.im = im;
            shift_window(v);
            if (fill < COEFF_TAPS)
                fill++;
            if (!last) begin
                if (fill >= m)
                    push_tap_sum(m, 1'b0);
                return;
            end
            // tail flush: pad a short sequence, then one output per sample
            cnt = (fill < m) ? fill : m;
            for (int unsigned r = cnt; r < m; r++)
                shift_window('0);
            for (int unsigned r = 0; r < cnt; r++) begin
                push_tap_sum(m, r + 1 == cnt);
                shift_window('0);
            end
            clear_window();
        endfunction

        function int unsigned pending();
            return pending_outputs.size();
        endfunction

        // accepted result against the oldest expected output
        function void compare_output(logic [ACC_W-1:0] re, logic [ACC_W-1:0] im, logic last,
                                     time stamp);
            filt_out_t e;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result re=%0d im=%0d last=%0b",
                         stamp, $signed(re), $signed(im), last);
                return;
            end
            e = pending_outputs.pop_front();
            if (re !== e.re || im !== e.im || last !== e.last) begin
                errors++;
                $display("%0t ns: result mismatch, expected re=%0d im=%0d last=%0b, actual re=%0d im=%0d last=%0b",
                         stamp, $signed(e.re), $signed(e.im), e.last,
                         $signed(re), $signed(im), last);
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/complex_fir_filter_tb.sv -----
// top testbench of the complex fir filter: stimulus, result checking, end of run
module complex_fir_filter_tb;
    import cfir_pkg::*;
    import cfir_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 150;
    localparam int SETTLE       = 32;

    logic clk;
    logic rst_n;
    bit   steady;

    cfir_sample_if sample_ch ();
    cfir_result_if result_ch ();
    cfir_cfg_if    cfg_ch ();

    filter_scoreboard sb = new();

    complex_fir_filter #(.TAPS(8)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle about a quarter of the cycles unless in a steady stretch
    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 26);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coeffs();
        case ($urandom_range(7))
            0:       return 64'h8000_8000_8000_8000;
            1:       return 64'h7FFF_7FFF_7FFF_7FFF;
            2:       return 64'h7FFF_8000_8000_7FFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one sample item, held until accepted
    task automatic send_sample(logic [SAMPLE_W-1:0] re, logic [SAMPLE_W-1:0] im, logic last);
        @(negedge clk);
        while (idle_now()) begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid       = 1'b1;
        sample_ch.sample_re   = re;
        sample_ch.sample_im   = im;
        sample_ch.last_sample = last;
        forever begin
            @(posedge clk);
            if (sample_ch.ready)
                break;
        end
        sb.accept_sample(re, im, last);
    endtask

    // stop sending, wait for every expected output, then let the block settle
    task automatic wait_for_drain();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic program_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wdata     = data;
        forever begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic program_all_coeffs(logic [CFG_DATA_W-1:0] data);
        program_reg(REG_COEFF_PAIR_0, data);
        program_reg(REG_COEFF_PAIR_1, data);
        program_reg(REG_COEFF_PAIR_2, data);
        program_reg(REG_COEFF_PAIR_3, data);
    endtask

    // result side: random stalls, check on every accepted item
    initial
    begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            result_ch.ready = !idle_now();
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.compare_output(result_ch.out_re, result_ch.out_im, result_ch.last_out, $time);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned random_items;
        int unsigned len;
        int unsigned tap;
        bit          closed;

        rst_n                 = 1'b0;
        steady                = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.sample_re   = '0;
        sample_ch.sample_im   = '0;
        sample_ch.last_sample = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = REG_TAP_COUNT;
        cfg_ch.wdata          = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extreme sum: every product at its extreme wraps the imag output
        program_reg(REG_TAP_COUNT, 64'd8);
        program_all_coeffs(64'h8000_8000_8000_8000);
        for (int k = 0; k < 8; k++)
            send_sample(16'h8000, 16'h8000, k == 7);
        wait_for_drain();

        // zero tap count acts as a single tap, extreme sample values
        program_reg(REG_TAP_COUNT, 64'd0);
        program_reg(REG_COEFF_PAIR_0, 64'h1234_5678_8000_7FFF);
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'h0000, 16'hFFFF, 1'b1);
        wait_for_drain();

        // tap count above the bank size, short sequences flushed by the last item
        program_reg(REG_TAP_COUNT, 64'd15);
        program_reg(REG_COEFF_PAIR_1, rand_coeffs());
        program_reg(REG_COEFF_PAIR_2, rand_coeffs());
        program_reg(REG_COEFF_PAIR_3, rand_coeffs());
        send_sample(rand_sample(), rand_sample(), 1'b0);
        send_sample(rand_sample(), rand_sample(), 1'b1);
        send_sample(rand_sample(), rand_sample(), 1'b1);
        wait_for_drain();

        // tap count lowered in the middle of a sequence
        program_reg(REG_TAP_COUNT, 64'd4);
        send_sample(rand_sample(), rand_sample(), 1'b0);
        send_sample(rand_sample(), rand_sample(), 1'b0);
        wait_for_drain();
        program_reg(REG_TAP_COUNT, 64'd2);
        send_sample(rand_sample(), rand_sample(), 1'b0);
        send_sample(rand_sample(), rand_sample(), 1'b1);
        wait_for_drain();

        // tap count raised in the middle of a sequence
        program_reg(REG_TAP_COUNT, 64'd1);
        send_sample(rand_sample(), rand_sample(), 1'b0);
        wait_for_drain();
        program_reg(REG_TAP_COUNT, 64'd3);
        send_sample(rand_sample(), rand_sample(), 1'b0);
        send_sample(rand_sample(), rand_sample(), 1'b1);
        wait_for_drain();

        // random sequences, some left open so the next one continues them
        random_items = 0;
        for (int seq = 0; random_items < RANDOM_ITEMS; seq++) begin
            steady = (seq >= 6 && seq < 12);
            if (seq == 0 || $urandom_range(3) == 0) begin
                wait_for_drain();
                tap = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
                program_reg(REG_TAP_COUNT, 64'(tap));
                if ($urandom_range(1))
                    program_reg(cfg_reg_e'($urandom_range(1, COEFF_PAIRS)), rand_coeffs());
            end
            len    = $urandom_range(1, 16);
            closed = ($urandom_range(9) != 0);
            for (int unsigned k = 0; k < len; k++) begin
                send_sample(rand_sample(), rand_sample(), closed && (k == len - 1));
                random_items++;
            end
        end
        steady = 1'b0;

        // close any open sequence, then let the last outputs drain
        send_sample(rand_sample(), rand_sample(), 1'b1);
        wait_for_drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
